FILE: rtl/core/datvt_pkg.sv
// ----------------------------------------------------------------------------
// Daily alarm table valve timer package
// Shared widths, command and status codes, the record that walks the cell
// chain, and the time-of-day helper.
// ----------------------------------------------------------------------------
package datvt_pkg;

    // Table size and field widths.
    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int TOD_W       = 11;
    localparam int SEC_W       = 17;
    localparam int DUR_W       = 11;
    localparam int CMD_W       = 3;
    localparam int STAT_W      = 2;

    // Time constants.
    localparam logic [TOD_W-1:0] MINUTES_PER_DAY    = 11'd1440;
    localparam logic [TOD_W-1:0] MINUTES_PER_HOUR   = 11'd60;
    localparam logic [SEC_W-1:0] SECONDS_PER_MINUTE = 17'd60;
    localparam logic [DUR_W-1:0] DEFAULT_DURATION   = 11'd15;
    localparam logic [MIN_W-1:0] NO_MINUTE          = 6'd63;
    localparam logic [SEC_W-1:0] OPEN_SECONDS_MAX   = '1;
    localparam logic [HOUR_W-1:0] LAST_HOUR         = 5'd23;
    localparam logic [MIN_W-1:0] LAST_MINUTE        = 6'd59;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FORCE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_TIME  = 2'd3;

    // Record handed from cell to cell while a command walks the table.
    // The hit flag means "slot taken", "entry removed", "match seen" or
    // "best entry found", depending on the command.
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [TOD_W-1:0]  cur;
        logic              hit;
        logic [TOD_W-1:0]  best;
        logic [HOUR_W-1:0] best_hour;
        logic [MIN_W-1:0]  best_minute;
        logic [CNT_W-1:0]  count;
    } t_carry;

    // Minutes since midnight.
    function automatic logic [TOD_W-1:0] to_minutes(input logic [HOUR_W-1:0] h,
                                                    input logic [MIN_W-1:0] m);
        return TOD_W'(h) * MINUTES_PER_HOUR + TOD_W'(m);
    endfunction

endpackage

FILE: rtl/core/daily_alarm_table_valve_timer.sv
// ----------------------------------------------------------------------------
// Daily alarm table valve timer
// Alarm table of daily times that opens a valve on a matching tick and closes
// it after a configured number of minutes.
// ----------------------------------------------------------------------------
// Each item walks a chain of MAX_ENTRIES cells, one cell per cycle, each cell
// holding one table slot. An accepted item passes the launch register, then
// each cell in turn; the sequencer sees the end of the chain and moves to its
// done state, where the valve state is computed and the result register is
// loaded once the result register is free. A new item is taken as soon as
// the result is loaded, even if it has not been collected yet. The
// duration_minutes register sits at byte address 0 of the APB port.
module daily_alarm_table_valve_timer
    import datvt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Command channel.
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [HOUR_W-1:0] i_hour,
    input  logic [MIN_W-1:0]  i_minute,
    input  logic              i_time_valid,
    // Result channel.
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic              o_valve_open,
    output logic              o_next_found,
    output logic [HOUR_W-1:0] o_next_hour,
    output logic [MIN_W-1:0]  o_next_minute,
    output logic [CNT_W-1:0]  o_entry_count,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam logic REG_DURATION = 1'b0;

    t_state             r_state;
    logic [DUR_W-1:0]   r_dur;
    logic               r_valve;
    logic [SEC_W-1:0]   r_open_sec;
    logic [MIN_W-1:0]   r_last_min;
    logic               r_tv;
    logic               r_ok;
    logic               r_launch_tok;
    t_carry             r_launch;

    logic               r_o_valid;
    logic [STAT_W-1:0]  r_o_status;
    logic               r_o_valve;
    logic               r_o_found;
    logic [HOUR_W-1:0]  r_o_hour;
    logic [MIN_W-1:0]   r_o_minute;
    logic [CNT_W-1:0]   r_o_count;

    logic               n_valve;
    logic [SEC_W-1:0]   n_open_sec;
    logic [MIN_W-1:0]   n_last_min;
    logic [STAT_W-1:0]  n_status;
    logic               n_found;
    logic [HOUR_W-1:0]  n_hour;
    logic [MIN_W-1:0]   n_minute;

    logic               in_acc;
    logic               out_free;
    logic               time_ok;
    logic [SEC_W-1:0]   dur_sec;
    t_carry             fin;

    logic   [MAX_ENTRIES:0] w_tok;
    t_carry                 w_carry [0:MAX_ENTRIES];

    // Handshakes.
    assign o_ready  = (r_state == S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign time_ok  = (i_hour <= LAST_HOUR) && (i_minute <= LAST_MINUTE);

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DURATION) ? 32'(r_dur) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur <= DEFAULT_DURATION;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_DURATION) begin
            r_dur <= pwdata[DUR_W-1:0];
        end
    end

    // Cell chain: the token and the record move one cell per cycle.
    assign w_tok[0]   = r_launch_tok;
    assign w_carry[0] = r_launch;

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        datvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[gi]),
            .i_carry (w_carry[gi]),
            .o_tok   (w_tok[gi+1]),
            .o_carry (w_carry[gi+1])
        );
    end

    assign fin     = w_carry[MAX_ENTRIES];
    assign dur_sec = SEC_W'(r_dur) * SECONDS_PER_MINUTE;

    // Result and valve update from the record that left the last cell.
    always_comb begin
        n_valve    = r_valve;
        n_open_sec = r_open_sec;
        n_last_min = r_last_min;
        n_status   = ST_OK;
        n_found    = 1'b0;
        n_hour     = '0;
        n_minute   = '0;
        unique case (fin.op)
            CMD_ADD: begin
                if (!r_ok) begin
                    n_status = ST_BAD_TIME;
                end else if (!fin.hit) begin
                    n_status = ST_FULL;
                end
            end
            CMD_DELETE: begin
                if (!fin.hit) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_STOP: begin
                if (fin.hit) begin
                    n_valve    = 1'b0;
                    n_open_sec = '0;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            CMD_FORCE: begin
                n_valve    = 1'b1;
                n_open_sec = '0;
            end
            CMD_TICK: begin
                if (r_valve && r_open_sec != OPEN_SECONDS_MAX) begin
                    n_open_sec = r_open_sec + 1'b1;
                end
                if (r_tv && !r_valve && r_last_min != fin.minute && fin.hit) begin
                    n_valve    = 1'b1;
                    n_open_sec = '0;
                    n_last_min = fin.minute;
                end
                if (n_valve && n_open_sec > dur_sec) begin
                    n_valve    = 1'b0;
                    n_open_sec = '0;
                end
            end
            CMD_QUERY: begin
                if (!r_ok) begin
                    n_status = ST_BAD_TIME;
                end else if (fin.hit) begin
                    n_found  = 1'b1;
                    n_hour   = fin.best_hour;
                    n_minute = fin.best_minute;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, launch stage and valve state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch_tok <= 1'b0;
            r_valve      <= 1'b0;
            r_open_sec   <= '0;
            r_last_min   <= NO_MINUTE;
            r_o_valid    <= 1'b0;
        end else begin
            r_launch_tok <= in_acc;
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_tok[MAX_ENTRIES]) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_valve    <= n_valve;
                        r_open_sec <= n_open_sec;
                        r_last_min <= n_last_min;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload into the chain; a bad add time is marked done up front.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tv                 <= i_time_valid;
            r_ok                 <= time_ok;
            r_launch.op          <= i_command;
            r_launch.hour        <= i_hour;
            r_launch.minute      <= i_minute;
            r_launch.cur         <= to_minutes(i_hour, i_minute);
            r_launch.hit         <= (i_command == CMD_ADD) && !time_ok;
            r_launch.best        <= '0;
            r_launch.best_hour   <= '0;
            r_launch.best_minute <= '0;
            r_launch.count       <= '0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status <= n_status;
            r_o_valve  <= n_valve;
            r_o_found  <= n_found;
            r_o_hour   <= n_hour;
            r_o_minute <= n_minute;
            r_o_count  <= fin.count;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_valve_open  = r_o_valve;
    assign o_next_found  = r_o_found;
    assign o_next_hour   = r_o_hour;
    assign o_next_minute = r_o_minute;
    assign o_entry_count = r_o_count;

    // At most one cell of the chain is working at any time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one token in the cell chain");

    // An accepted item starts the chain walk in the next cycle.
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN) && w_tok[0])
        else $error("accepted item did not launch into the chain");

    // A found entry is always a legal time of day.
    a_next_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_next_found) |->
            (o_next_hour <= LAST_HOUR) && (o_next_minute <= LAST_MINUTE))
        else $error("query result holds an illegal time");

    // The used count never exceeds the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CNT_W'(MAX_ENTRIES)))
        else $error("entry count beyond table size");

endmodule

FILE: rtl/core/datvt_cell.sv
// ----------------------------------------------------------------------------
// Alarm table cell
// Holds one alarm slot. When the token reaches it, the cell applies the
// command in the incoming record to its slot and passes the record on.
// ----------------------------------------------------------------------------
module datvt_cell
    import datvt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_tok,
    input  t_carry i_carry,
    output logic   o_tok,
    output t_carry o_carry
);

    logic              r_used;
    logic [HOUR_W-1:0] r_hour;
    logic [MIN_W-1:0]  r_minute;
    logic              r_tok;
    t_carry            r_carry;

    logic              n_used;
    logic [HOUR_W-1:0] n_hour;
    logic [MIN_W-1:0]  n_minute;
    t_carry            n_carry;

    logic              match;
    logic [TOD_W-1:0]  slot_tod;
    logic [TOD_W-1:0]  fwd_gap;

    // Slot compare and forward circular distance from the query time.
    assign match    = r_used && (r_hour == i_carry.hour) && (r_minute == i_carry.minute);
    assign slot_tod = to_minutes(r_hour, r_minute);
    assign fwd_gap  = (slot_tod >= i_carry.cur)
                    ? (slot_tod - i_carry.cur)
                    : (MINUTES_PER_DAY - i_carry.cur + slot_tod);

    // Apply the command to this slot.
    always_comb begin
        n_used   = r_used;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_carry  = i_carry;
        unique case (i_carry.op)
            CMD_ADD: begin
                if (!i_carry.hit && !r_used) begin
                    n_used      = 1'b1;
                    n_hour      = i_carry.hour;
                    n_minute    = i_carry.minute;
                    n_carry.hit = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!i_carry.hit && match) begin
                    n_used      = 1'b0;
                    n_carry.hit = 1'b1;
                end
            end
            CMD_STOP, CMD_TICK: begin
                if (match) begin
                    n_carry.hit = 1'b1;
                end
            end
            CMD_QUERY: begin
                // Strict compare keeps the lowest slot on a tie.
                if (r_used && (!i_carry.hit || fwd_gap < i_carry.best)) begin
                    n_carry.hit         = 1'b1;
                    n_carry.best        = fwd_gap;
                    n_carry.best_hour   = r_hour;
                    n_carry.best_minute = r_minute;
                end
            end
            default: begin
            end
        endcase
        n_carry.count = i_carry.count + CNT_W'(n_used);
    end

    // Slot storage and the stage register toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= 1'b0;
            r_hour   <= '0;
            r_minute <= '0;
            r_tok    <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_tok) begin
                r_used   <= n_used;
                r_hour   <= n_hour;
                r_minute <= n_minute;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_carry <= n_carry;
        end
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Daily alarm table valve timer testbench
// Sends add, delete, stop, force, tick and query commands through the valid /
// ready channel and predicts every result with a cycle-free model of the
// alarm table and valve timer. Results are checked field by field in order.
// The open duration is changed over the APB port between phases while the
// block is idle. A directed pass covers the edge cases, then random phases
// run with different idle patterns on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import datvt_pkg::*;

    // Run parameters.
    localparam int         PIPE_LATENCY  = MAX_ENTRIES + 3;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         MAX_REPORTS   = 10;
    localparam int         NO_DISTANCE   = 9999;
    localparam int         PHASE_ITEMS   = 360;
    localparam logic [2:0] REG_DURATION  = 3'd0;

    // Command codes the block ignores.
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    // One result item.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              valve;
        logic              found;
        logic [HOUR_W-1:0] next_hour;
        logic [MIN_W-1:0]  next_minute;
        logic [CNT_W-1:0]  count;
    } t_alarm_result;

    // DUT signals.
    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [CMD_W-1:0]  i_command;
    logic [HOUR_W-1:0] i_hour;
    logic [MIN_W-1:0]  i_minute;
    logic              i_time_valid;
    logic              o_valid;
    logic              i_ready;
    logic [STAT_W-1:0] o_status;
    logic              o_valve_open;
    logic              o_next_found;
    logic [HOUR_W-1:0] o_next_hour;
    logic [MIN_W-1:0]  o_next_minute;
    logic [CNT_W-1:0]  o_entry_count;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted table, valve and configuration.
    logic [HOUR_W-1:0] tbl_hour [MAX_ENTRIES];
    logic [MIN_W-1:0]  tbl_min  [MAX_ENTRIES];
    logic              tbl_used [MAX_ENTRIES];
    logic              valve_is_open;
    logic [SEC_W-1:0]  valve_open_secs;
    logic [MIN_W-1:0]  last_alarm_minute;
    logic [DUR_W-1:0]  open_minutes;

    // Results still to come from the block, oldest first.
    t_alarm_result pending_alarm_results[$];

    // Run bookkeeping.
    int send_idle_pct;
    int recv_idle_pct;
    int fail_count;
    int results_checked;
    int stall_cycles;
    int alarm_openings;
    int status_seen [4];
    int cmd_seen [8];

    daily_alarm_table_valve_timer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_hour        (i_hour),
        .i_minute      (i_minute),
        .i_time_valid  (i_time_valid),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_valve_open  (o_valve_open),
        .o_next_found  (o_next_found),
        .o_next_hour   (o_next_hour),
        .o_next_minute (o_next_minute),
        .o_entry_count (o_entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with an 8 ns period.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Count a failure and report the first few of them.
    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic int count_entries();
        int n;
        n = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (tbl_used[i]) n++;
        end
        return n;
    endfunction

    function automatic int find_entry(input logic [HOUR_W-1:0] h,
                                      input logic [MIN_W-1:0] m);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (tbl_used[i] && tbl_hour[i] == h && tbl_min[i] == m) return i;
        end
        return -1;
    endfunction

    // Apply one command to the predicted state and return the result it gives.
    function automatic t_alarm_result advance_alarm_table(input logic [CMD_W-1:0] cmd,
                                                          input logic [HOUR_W-1:0] h,
                                                          input logic [MIN_W-1:0] m,
                                                          input logic tv);
        t_alarm_result r;
        int slot;
        int cur;
        int t;
        int d;
        int best;
        logic in_range;
        r = '0;
        slot = find_entry(h, m);
        in_range = (h <= LAST_HOUR) && (m <= LAST_MINUTE);
        case (cmd)
            CMD_ADD: begin
                if (!in_range) begin
                    r.status = ST_BAD_TIME;
                end else begin
                    // Take the lowest free slot, if any.
                    r.status = ST_FULL;
                    for (int i = 0; i < MAX_ENTRIES && r.status == ST_FULL; i++) begin
                        if (!tbl_used[i]) begin
                            tbl_used[i] = 1'b1;
                            tbl_hour[i] = h;
                            tbl_min[i]  = m;
                            r.status    = ST_OK;
                        end
                    end
                end
            end
            CMD_DELETE: begin
                if (slot < 0) r.status = ST_NOT_FOUND;
                else tbl_used[slot] = 1'b0;
            end
            CMD_STOP: begin
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    valve_is_open   = 1'b0;
                    valve_open_secs = '0;
                end
            end
            CMD_FORCE: begin
                valve_is_open   = 1'b1;
                valve_open_secs = '0;
            end
            CMD_TICK: begin
                if (valve_is_open && valve_open_secs < OPEN_SECONDS_MAX) begin
                    valve_open_secs = valve_open_secs + 1'b1;
                end
                // A matching alarm opens a closed valve once per minute number.
                if (tv && !valve_is_open && last_alarm_minute != m && slot >= 0) begin
                    valve_is_open     = 1'b1;
                    valve_open_secs   = '0;
                    last_alarm_minute = m;
                    alarm_openings++;
                end
                if (valve_is_open &&
                    int'(valve_open_secs) > int'(open_minutes) * int'(SECONDS_PER_MINUTE)) begin
                    valve_is_open   = 1'b0;
                    valve_open_secs = '0;
                end
            end
            CMD_QUERY: begin
                if (!in_range) begin
                    r.status = ST_BAD_TIME;
                end else begin
                    // Closest entry ahead, wrapping past midnight; lowest slot wins ties.
                    cur  = int'(h) * int'(MINUTES_PER_HOUR) + int'(m);
                    best = NO_DISTANCE;
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (tbl_used[i]) begin
                            t = int'(tbl_hour[i]) * int'(MINUTES_PER_HOUR) + int'(tbl_min[i]);
                            d = (t >= cur) ? (t - cur) : (int'(MINUTES_PER_DAY) - cur + t);
                            if (d < best) begin
                                best          = d;
                                r.found       = 1'b1;
                                r.next_hour   = tbl_hour[i];
                                r.next_minute = tbl_min[i];
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.valve = valve_is_open;
        r.count = CNT_W'(count_entries());
        status_seen[r.status]++;
        cmd_seen[cmd]++;
        return r;
    endfunction

    // Send one item; entered and left at a falling edge.
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HOUR_W-1:0] h,
                                input logic [MIN_W-1:0] m, input logic tv);
        t_alarm_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_command    = cmd;
        i_hour       = h;
        i_minute     = m;
        i_time_valid = tv;
        do @(posedge i_clk); while (!o_ready);
        pred = advance_alarm_table(cmd, h, m, tv);
        pending_alarm_results.insert(pending_alarm_results.size(), pred);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every result has come back.
    task automatic wait_until_idle();
        i_valid = 1'b0;
        while (pending_alarm_results.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the open duration over APB and read it back.
    task automatic write_duration(input logic [DUR_W-1:0] minutes);
        logic [31:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = REG_DURATION;
        pwdata  = 32'(minutes);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        open_minutes = minutes;
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== 32'(minutes)) begin
            note_failure($sformatf("duration readback exp %0d got %0d", minutes, readback));
        end
    endtask

    // Pick the time of a random used entry; returns 0 on an empty table.
    function automatic logic pick_entry_time(output logic [HOUR_W-1:0] h,
                                             output logic [MIN_W-1:0] m);
        int start;
        int idx;
        start = $urandom_range(MAX_ENTRIES - 1);
        h = '0;
        m = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            idx = (start + i) % MAX_ENTRIES;
            if (tbl_used[idx]) begin
                h = tbl_hour[idx];
                m = tbl_min[idx];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Table edits and queries on the field extremes.
    task automatic test_table_edits();
        send_command(CMD_QUERY, 5'd12, 6'd0, 1'b1);
        send_command(CMD_ADD, 5'd23, 6'd59, 1'b0);
        send_command(CMD_ADD, 5'd0, 6'd0, 1'b1);
        send_command(CMD_ADD, 5'd24, 6'd0, 1'b1);
        send_command(CMD_ADD, 5'd0, 6'd60, 1'b0);
        send_command(CMD_ADD, 5'd31, 6'd63, 1'b1);
        send_command(CMD_QUERY, 5'd23, 6'd59, 1'b0);
        send_command(CMD_QUERY, 5'd0, 6'd1, 1'b1);
        send_command(CMD_QUERY, 5'd24, 6'd0, 1'b1);
        send_command(CMD_DELETE, 5'd5, 6'd5, 1'b0);
        send_command(CMD_DELETE, 5'd0, 6'd0, 1'b1);
        send_command(CMD_STOP, 5'd7, 6'd7, 1'b1);
    endtask

    // Force, stop, alarm matching and the duration timeout.
    task automatic test_valve_control();
        send_command(CMD_FORCE, 5'd0, 6'd0, 1'b0);
        send_command(CMD_FORCE, 5'd31, 6'd63, 1'b1);
        send_command(CMD_STOP, 5'd23, 6'd59, 1'b0);
        wait_until_idle();
        write_duration('0);
        send_command(CMD_ADD, 5'd6, 6'd30, 1'b1);
        // Time not set, then a match, then the timeout on the next tick.
        send_command(CMD_TICK, 5'd6, 6'd30, 1'b0);
        send_command(CMD_TICK, 5'd6, 6'd30, 1'b1);
        send_command(CMD_TICK, 5'd6, 6'd31, 1'b1);
        // Same minute number again is held off; a new minute fires.
        send_command(CMD_TICK, 5'd6, 6'd30, 1'b1);
        send_command(CMD_TICK, 5'd23, 6'd59, 1'b1);
        send_command(CMD_TICK, 5'd0, 6'd0, 1'b1);
        send_command(CMD_SPARE_6, 5'd31, 6'd63, 1'b1);
        send_command(CMD_SPARE_7, 5'd0, 6'd0, 1'b0);
    endtask

    // Random traffic, mostly well-formed commands around the stored times.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int sel;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0] m;
        logic have;
        sent = 0;
        // Fill the table with random times and overflow it once.
        while (count_entries() < MAX_ENTRIES) begin
            send_command(CMD_ADD, HOUR_W'($urandom_range(23)), MIN_W'($urandom_range(59)),
                         1'($urandom));
            sent++;
        end
        send_command(CMD_ADD, HOUR_W'($urandom_range(23)), MIN_W'($urandom_range(59)), 1'b1);
        sent++;
        while (sent < n_items) begin
            sel  = $urandom_range(99);
            h    = HOUR_W'($urandom_range(23));
            m    = MIN_W'($urandom_range(59));
            have = pick_entry_time(h, m);
            if (!have || $urandom_range(99) < 30) begin
                h = HOUR_W'($urandom_range(23));
                m = MIN_W'($urandom_range(59));
            end
            if (sel < 40) begin
                send_command(CMD_TICK, h, m, $urandom_range(99) < 90);
            end else if (sel < 54) begin
                if ($urandom_range(99) < 15) begin
                    h = HOUR_W'($urandom);
                    m = MIN_W'($urandom);
                end
                send_command(CMD_ADD, h, m, 1'($urandom));
            end else if (sel < 66) begin
                send_command(CMD_DELETE, h, m, 1'($urandom));
            end else if (sel < 78) begin
                if ($urandom_range(99) < 15) begin
                    h = HOUR_W'($urandom);
                    m = MIN_W'($urandom);
                end
                send_command(CMD_QUERY, h, m, 1'($urandom));
            end else if (sel < 86) begin
                send_command(CMD_STOP, h, m, 1'($urandom));
            end else if (sel < 92) begin
                send_command(CMD_FORCE, HOUR_W'($urandom), MIN_W'($urandom), 1'($urandom));
            end else if (sel < 96) begin
                // Noise: any of the six command codes with any field values.
                send_command(CMD_W'($urandom_range(5)), HOUR_W'($urandom), MIN_W'($urandom),
                             1'($urandom));
            end else begin
                send_command($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, HOUR_W'($urandom),
                             MIN_W'($urandom), 1'($urandom));
                sent--;
            end
            sent++;
        end
    endtask

    // Result side: random ready at the falling edge.
    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each collected result with the oldest prediction.
    always @(posedge i_clk) begin
        t_alarm_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (pending_alarm_results.size() == 0) begin
                note_failure("result with no item outstanding");
            end else begin
                exp_res = pending_alarm_results.pop_front();
                if (o_status !== exp_res.status || o_valve_open !== exp_res.valve ||
                    o_next_found !== exp_res.found || o_next_hour !== exp_res.next_hour ||
                    o_next_minute !== exp_res.next_minute ||
                    o_entry_count !== exp_res.count) begin
                    note_failure({
                        $sformatf("exp st=%0d valve=%0d found=%0d next=%0d:%0d cnt=%0d",
                                  exp_res.status, exp_res.valve, exp_res.found,
                                  exp_res.next_hour, exp_res.next_minute, exp_res.count),
                        $sformatf(", got st=%0d valve=%0d found=%0d next=%0d:%0d cnt=%0d",
                                  o_status, o_valve_open, o_next_found, o_next_hour,
                                  o_next_minute, o_entry_count)});
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Main sequence.
    initial begin
        string cover_line;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_command    = CMD_ADD;
        i_hour       = '0;
        i_minute     = '0;
        i_time_valid = 1'b0;
        i_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = REG_DURATION;
        pwdata       = '0;
        fail_count      = 0;
        results_checked = 0;
        stall_cycles    = 0;
        alarm_openings  = 0;
        status_seen     = '{default: 0};
        cmd_seen        = '{default: 0};
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tbl_hour[i] = '0;
            tbl_min[i]  = '0;
            tbl_used[i] = 1'b0;
        end
        valve_is_open     = 1'b0;
        valve_open_secs   = '0;
        last_alarm_minute = NO_MINUTE;
        open_minutes      = DEFAULT_DURATION;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_edits();
        test_valve_control();

        // Sender idles rarely, receiver often; valve closes after one tick.
        wait_until_idle();
        send_idle_pct = 19;
        recv_idle_pct = 82;
        test_random_traffic(PHASE_ITEMS);

        // Roles swapped; a full-day duration keeps the valve open until stopped.
        wait_until_idle();
        write_duration(DUR_W'(1440));
        send_idle_pct = 82;
        recv_idle_pct = 19;
        test_random_traffic(PHASE_ITEMS);

        // Back to back on both sides with a one minute duration.
        wait_until_idle();
        write_duration(DUR_W'(1));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(PHASE_ITEMS);

        wait_until_idle();
        if (pending_alarm_results.size() != 0) begin
            note_failure("predictions left without a result");
        end
        cover_line = {
            $sformatf("covered: add %0d, delete %0d, stop %0d, force %0d, ",
                      cmd_seen[CMD_ADD], cmd_seen[CMD_DELETE], cmd_seen[CMD_STOP],
                      cmd_seen[CMD_FORCE]),
            $sformatf("tick %0d, query %0d, ignored %0d; %0d results checked",
                      cmd_seen[CMD_TICK], cmd_seen[CMD_QUERY],
                      cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7], results_checked)};
        $display("%s", cover_line);
        $display("alarm openings %0d, table full %0d, not found %0d, bad time %0d, %0d mismatches",
                 alarm_openings, status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_BAD_TIME], fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/datvt_pkg.sv
rtl/core/datvt_cell.sv
rtl/core/daily_alarm_table_valve_timer.sv
tb/sv/testbench.sv
